### rtl/itoa_fmt_pkg.sv
// ----------------------------------------------------------------------------
// itoa_fmt_pkg
// Types, codes and character constants shared by the integer to ASCII
// formatter files.
// ----------------------------------------------------------------------------
`default_nettype none

package itoa_fmt_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned PAD_W   = 6;
  localparam int unsigned CH_W    = 7;

  // ten bcd digits cover the full 32-bit range
  localparam int unsigned BCD_DIGITS = 10;
  localparam int unsigned DIG_W      = 4 * BCD_DIGITS;
  localparam int unsigned HEX_DIGITS = VALUE_W / 4;
  localparam int unsigned NDIG_W     = 4;

  typedef logic [FUNC_W-1:0]  func_t;
  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [PAD_W-1:0]   pad_t;
  typedef logic [CH_W-1:0]    ch_t;
  typedef logic [NDIG_W-1:0]  ndig_t;

  localparam func_t FUNC_HEX  = 2'd0;
  localparam func_t FUNC_UDEC = 2'd1;
  localparam func_t FUNC_SDEC = 2'd2;
  localparam func_t FUNC_NONE = 2'd3;

  localparam ch_t CH_ZERO  = 7'h30;
  localparam ch_t CH_UPA   = 7'h41;
  localparam ch_t CH_MINUS = 7'h2d;
  localparam ch_t CH_SPACE = 7'h20;
  localparam ch_t CH_X     = 7'h78;

  localparam logic [3:0] HEX_TEN = 4'ha;

  // command word from the sequencer to the digit unit
  typedef struct packed {
    logic load_hex;
    logic load_dec;
    logic dabble;
    logic shift;
  } dig_cmd_t;

  function automatic ch_t digit_char(input logic [3:0] d);
    ch_t c;
    if (d < HEX_TEN) begin
      c = CH_ZERO + {3'b000, d};
    end else begin
      c = CH_UPA + {3'b000, d - HEX_TEN};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/itoa_fmt_if.sv
// ----------------------------------------------------------------------------
// itoa_fmt interfaces
// Valid/ready channels for the formatter: operand items in, characters out.
// ----------------------------------------------------------------------------
`default_nettype none

interface itoa_fmt_in_if;
  logic                  valid;
  logic                  ready;
  itoa_fmt_pkg::func_t   func;
  itoa_fmt_pkg::value_t  value;
  itoa_fmt_pkg::pad_t    pad_width;
  logic                  prefix;

  modport source (output valid, func, value, pad_width, prefix, input ready);
  modport sink   (input valid, func, value, pad_width, prefix, output ready);
endinterface

interface itoa_fmt_out_if;
  logic               valid;
  logic               ready;
  itoa_fmt_pkg::ch_t  ch;
  logic               last;

  modport source (output valid, ch, last, input ready);
  modport sink   (input valid, ch, last, output ready);
endinterface

`default_nettype wire

### rtl/integer_to_ascii_formatter_core.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// Turns a 32-bit value into upper-case hex or decimal ASCII text, one
// character per transfer, with optional 0x prefix and trailing space padding.
// ----------------------------------------------------------------------------
//  channel  dir  payload                          handshake
//  item     in   func, value, pad_width, prefix   valid/ready
//  text     out  ch, last                         valid/ready
//
//  hex: accept, then trim (drop leading zeros, keeping at least one digit,
//    then fix the length), then emit the characters
//  decimal: accept, then double dabble on the digit unit over every value
//    bit, then trim as for hex, then emit the characters (at most PAD_MAX
//    characters, 60 by default)
//  item.ready is high only between items; func 3 is taken and yields nothing
//  a stalled text transfer holds the sequencer; reset is synchronous
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_formatter_core #(
  parameter int unsigned PAD_MAX = 60
) (
  input  wire             clk,
  input  wire             rst,
  itoa_fmt_in_if.sink     item,
  itoa_fmt_out_if.source  text
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DABBLE = 3'd1;
  localparam logic [2:0] S_TRIM   = 3'd2;
  localparam logic [2:0] S_EMIT   = 3'd3;

  localparam itoa_fmt_pkg::pad_t PAD_W_MAX = itoa_fmt_pkg::PAD_W'(PAD_MAX);

  logic [2:0]               state;
  logic                     is_hex;
  logic                     neg;
  logic                     pre;
  itoa_fmt_pkg::pad_t       pad;
  itoa_fmt_pkg::ndig_t      ndig;
  logic [4:0]               step;
  itoa_fmt_pkg::pad_t       idx;
  itoa_fmt_pkg::pad_t       total;
  logic [1:0]               lead;

  logic                     out_valid;
  itoa_fmt_pkg::ch_t        out_ch;
  logic                     out_last;

  itoa_fmt_pkg::dig_cmd_t   cmd;
  itoa_fmt_pkg::value_t     load_val;
  logic [3:0]               top;

  itoa_fmt_pkg::pad_t       pad_sat;
  itoa_fmt_pkg::pad_t       pad_hex;
  itoa_fmt_pkg::pad_t       ndig_ext;
  itoa_fmt_pkg::pad_t       total_next;
  logic [1:0]               lead_next;
  logic                     in_fire;
  logic                     emit_go;
  logic                     trim_more;
  itoa_fmt_pkg::ch_t        emit_ch;
  logic                     emit_digit;

  assign in_fire   = item.valid && item.ready;
  assign item.ready = (state == S_IDLE);
  assign emit_go   = (state == S_EMIT) && (!out_valid || text.ready);
  assign trim_more = (top == 4'h0) && (ndig > 4'd1);

  assign pad_sat = (item.pad_width > PAD_W_MAX) ? PAD_W_MAX : item.pad_width;

  // field length once leading zeros are gone
  always_comb begin
    ndig_ext = {2'b00, ndig};
    pad_hex  = (pre && pad >= 6'd2) ? pad - 6'd2 : pad;
    if (is_hex) begin
      total_next = ((ndig_ext > pad_hex) ? ndig_ext : pad_hex) + (pre ? 6'd2 : 6'd0);
      lead_next  = {pre, 1'b0};
    end else begin
      total_next = (pad == '0) ? ndig_ext + {5'd0, neg} : pad;
      lead_next  = {1'b0, neg};
    end
  end

  // character picked at the current position
  always_comb begin
    emit_digit = 1'b0;
    if ({4'd0, lead} > idx) begin
      if (is_hex) begin
        emit_ch = idx[0] ? itoa_fmt_pkg::CH_X : itoa_fmt_pkg::CH_ZERO;
      end else begin
        emit_ch = itoa_fmt_pkg::CH_MINUS;
      end
    end else if (ndig != '0) begin
      emit_ch    = itoa_fmt_pkg::digit_char(top);
      emit_digit = 1'b1;
    end else begin
      emit_ch = itoa_fmt_pkg::CH_SPACE;
    end
  end

  always_comb begin
    cmd      = '0;
    load_val = item.value;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          case (item.func)
            itoa_fmt_pkg::FUNC_HEX:  cmd.load_hex = 1'b1;
            itoa_fmt_pkg::FUNC_UDEC: cmd.load_dec = 1'b1;
            itoa_fmt_pkg::FUNC_SDEC: begin
              cmd.load_dec = 1'b1;
              if (item.value[31]) begin
                load_val = 32'd0 - item.value;
              end
            end
            default: ;
          endcase
        end
      end
      S_DABBLE: cmd.dabble = 1'b1;
      S_TRIM:   cmd.shift  = trim_more;
      S_EMIT:   cmd.shift  = emit_go && emit_digit;
      default: ;
    endcase
  end

  itoa_fmt_digits u_digits (
    .clk   (clk),
    .cmd   (cmd),
    .value (load_val),
    .top   (top)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (text.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            pad  <= pad_sat;
            pre  <= item.prefix;
            step <= '0;
            case (item.func)
              itoa_fmt_pkg::FUNC_HEX: begin
                is_hex <= 1'b1;
                neg    <= 1'b0;
                ndig   <= itoa_fmt_pkg::NDIG_W'(itoa_fmt_pkg::HEX_DIGITS);
                state  <= S_TRIM;
              end
              itoa_fmt_pkg::FUNC_UDEC, itoa_fmt_pkg::FUNC_SDEC: begin
                is_hex <= 1'b0;
                neg    <= (item.func == itoa_fmt_pkg::FUNC_SDEC) && item.value[31];
                ndig   <= itoa_fmt_pkg::NDIG_W'(itoa_fmt_pkg::BCD_DIGITS);
                state  <= S_DABBLE;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_DABBLE: begin
          step <= step + 5'd1;
          if (step == 5'd31) begin
            state <= S_TRIM;
          end
        end
        S_TRIM: begin
          if (trim_more) begin
            ndig <= ndig - 4'd1;
          end else begin
            total <= total_next;
            lead  <= lead_next;
            idx   <= '0;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_ch    <= emit_ch;
            out_last  <= (idx == total - 6'd1);
            idx       <= idx + 6'd1;
            if (emit_digit) begin
              ndig <= ndig - 4'd1;
            end
            if (idx == total - 6'd1) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign text.valid = out_valid;
  assign text.ch    = out_ch;
  assign text.last  = out_last;

endmodule

`default_nettype wire

### rtl/itoa_fmt_digits.sv
// ----------------------------------------------------------------------------
// itoa_fmt_digits
// Digit register with one shared shift/add-3 unit: loads hex nibbles or a binary
// value, runs double dabble one bit per cycle, and shifts digits out from the top.
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_fmt_digits (
  input  wire                        clk,
  input  wire itoa_fmt_pkg::dig_cmd_t cmd,
  input  wire itoa_fmt_pkg::value_t  value,
  output logic [3:0]                 top
);

  logic [itoa_fmt_pkg::DIG_W-1:0]   dig;
  logic [itoa_fmt_pkg::VALUE_W-1:0] bin;
  logic [itoa_fmt_pkg::DIG_W-1:0]   corr;

  // add 3 to every bcd digit that is 5 or more before the shift
  always_comb begin
    for (int i = 0; i < itoa_fmt_pkg::BCD_DIGITS; i++) begin
      if (dig[4*i +: 4] >= 4'd5) begin
        corr[4*i +: 4] = dig[4*i +: 4] + 4'd3;
      end else begin
        corr[4*i +: 4] = dig[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_hex) begin
      dig <= {value, {(itoa_fmt_pkg::DIG_W - itoa_fmt_pkg::VALUE_W){1'b0}}};
    end else if (cmd.load_dec) begin
      dig <= '0;
      bin <= value;
    end else if (cmd.dabble) begin
      {dig, bin} <= {corr[itoa_fmt_pkg::DIG_W-2:0], bin, 1'b0};
    end else if (cmd.shift) begin
      dig <= {dig[itoa_fmt_pkg::DIG_W-5:0], 4'h0};
    end
  end

  assign top = dig[itoa_fmt_pkg::DIG_W-1 -: 4];

endmodule

`default_nettype wire

### rtl/itoa_fmt_check.sv
// ----------------------------------------------------------------------------
// itoa_fmt_check
// Port-level checks for the integer to ASCII formatter, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_fmt_check (
  input wire                       clk,
  input wire                       rst,
  input wire                       in_valid,
  input wire                       in_ready,
  input wire itoa_fmt_pkg::func_t  in_func,
  input wire                       out_valid,
  input wire                       out_ready,
  input wire itoa_fmt_pkg::ch_t    out_ch,
  input wire                       out_last
);

  // a real conversion keeps the input side closed for the next cycle
  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_func != itoa_fmt_pkg::FUNC_NONE) |=> !in_ready)
    else $error("input taken right after a conversion item");

  // mid-item characters mean the sequencer is still busy
  a_no_accept_mid_item: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> !in_ready)
    else $error("input ready while an item is still being emitted");

  // only digits, A-F, minus, x and space are ever produced
  a_char_set: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_ch >= 7'h30 && out_ch <= 7'h39) ||
                   (out_ch >= 7'h41 && out_ch <= 7'h46) ||
                   out_ch == itoa_fmt_pkg::CH_MINUS ||
                   out_ch == itoa_fmt_pkg::CH_X ||
                   out_ch == itoa_fmt_pkg::CH_SPACE))
    else $error("unexpected character code");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_ch) && $stable(out_last)))
    else $error("stalled character changed");

endmodule

bind integer_to_ascii_formatter_core itoa_fmt_check u_itoa_fmt_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .in_func   (item.func),
  .out_valid (text.valid),
  .out_ready (text.ready),
  .out_ch    (text.ch),
  .out_last  (text.last)
);

`default_nettype wire
